@@ src/bmp24_pkg.sv @@
// ============================================================================
// bmp24_pkg
// Shared constants, header offsets, codes and the result record of the 24-bit
// BMP stream decoder.
// ============================================================================
package bmp24_pkg;

    localparam int DISPLAY_WIDTH  = 240;
    localparam int DISPLAY_HEIGHT = 320;
    localparam int UI_RESERVE     = 28;
    localparam int UI_HALF        = 14;

    localparam int CW = $clog2(DISPLAY_WIDTH + 1);
    localparam int CH = $clog2(DISPLAY_HEIGHT + 1);

    localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
    localparam logic [15:0] BMP_PLANES    = 16'd1;
    localparam logic [15:0] BMP_DEPTH     = 16'd24;
    localparam logic [31:0] HEADER_LEN    = 32'd34;

    localparam logic [31:0] POS_SIG    = 32'd1;
    localparam logic [31:0] POS_OFFSET = 32'd13;
    localparam logic [31:0] POS_WIDTH  = 32'd21;
    localparam logic [31:0] POS_HEIGHT = 32'd25;
    localparam logic [31:0] POS_CROP   = 32'd26;
    localparam logic [31:0] POS_CENTRE = 32'd27;
    localparam logic [31:0] POS_PLANES = 32'd27;
    localparam logic [31:0] POS_DEPTH  = 32'd29;
    localparam logic [31:0] POS_COMP   = 32'd33;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_DATA   = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    localparam logic [1:0] COMP_BLUE  = 2'd0;
    localparam logic [1:0] COMP_GREEN = 2'd1;
    localparam logic [1:0] COMP_RED   = 2'd2;

    localparam logic CFG_ORIGIN_X = 1'b0;
    localparam logic CFG_ORIGIN_Y = 1'b1;

    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    typedef struct packed {
        logic       result_kind;
        logic [8:0] pixel_x;
        logic [9:0] pixel_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_pixel;
    } result_t;

endpackage

@@ src/bmp24_parser.sv @@
// ============================================================================
// bmp24_parser
// Byte-at-a-time header parser, cropper and pixel assembler. Each accepted
// byte updates the parse state and yields at most one result in one pass.
// ============================================================================
module bmp24_parser
    import bmp24_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] file_byte,
    input  logic       first_byte,
    input  logic [7:0] origin_x,
    input  logic [7:0] origin_y,
    output logic       res_valid,
    output result_t    res
);

    localparam logic signed [33:0] W_LIMIT = 34'(DISPLAY_WIDTH + 1);
    localparam logic signed [33:0] W_FULL  = 34'(DISPLAY_WIDTH);
    localparam logic signed [33:0] H_LIMIT = 34'(DISPLAY_HEIGHT - UI_RESERVE + 1);
    localparam logic signed [33:0] H_FULL  = 34'(DISPLAY_HEIGHT - UI_HALF);
    localparam logic signed [CH+1:0] H_AREA = (CH + 2)'(DISPLAY_HEIGHT - UI_RESERVE);

    logic [31:0]   byte_pos_reg, byte_pos_next;
    logic [1:0]    phase_reg, phase_next;
    logic [31:0]   shift_reg, shift_next;
    logic [31:0]   data_start_reg, data_start_next;
    logic [31:0]   image_width_reg, image_width_next;
    logic [31:0]   image_rows_reg, image_rows_next;
    logic          bottom_up_reg, bottom_up_next;
    logic [CW-1:0] crop_w_reg, crop_w_next;
    logic [CH-1:0] crop_h_reg, crop_h_next;
    logic          crop_empty_reg, crop_empty_next;
    logic [7:0]    left_x_reg, left_x_next;
    logic [7:0]    top_y_reg, top_y_next;
    logic [33:0]   row_bytes_reg, row_bytes_next;
    logic [33:0]   byte_in_row_reg, byte_in_row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [1:0]    comp_reg, comp_next;
    logic [32:0]   drow_reg, drow_next;
    logic [15:0]   held_bg_reg, held_bg_next;

    logic [31:0]   pos;
    logic [1:0]    phase_cur;
    logic [31:0]   shift_new;
    logic          off_screen;
    logic          bad;

    logic signed [33:0] x_s, y_s, w_s, h_s, w_c, h_c;
    logic [33:0]        rb_sum;
    logic [CW:0]        w_gap;
    logic signed [CH+1:0] h_gap, h_half;
    logic [7:0]         left_c, top_c;

    logic row_ok, col_ok, row_end, last_col, last_row, last;

    assign pos        = first_byte ? '0 : byte_pos_reg;
    assign phase_cur  = first_byte ? PH_HEADER : phase_reg;
    assign shift_new  = {file_byte, (first_byte ? 24'd0 : shift_reg[31:8])};
    assign off_screen = (32'(origin_x) >= 32'(DISPLAY_WIDTH))
                     || (32'(origin_y) >= 32'(DISPLAY_HEIGHT));

    assign x_s = $signed({26'd0, left_x_reg});
    assign y_s = $signed({26'd0, top_y_reg});
    assign w_s = $signed({{2{image_width_reg[31]}}, image_width_reg});
    assign h_s = $signed({2'd0, image_rows_reg});
    assign w_c = (x_s + w_s >= W_LIMIT) ? W_FULL - x_s : w_s;
    assign h_c = (y_s + h_s >= H_LIMIT) ? H_FULL - y_s : h_s;
    assign rb_sum = {1'b0, image_width_reg, 1'b0} + {2'd0, image_width_reg} + 34'd3;

    assign w_gap  = (CW + 1)'(DISPLAY_WIDTH) - {1'b0, crop_w_reg};
    assign h_gap  = H_AREA - $signed({2'b00, crop_h_reg});
    assign h_half = (h_gap + $signed((CH + 2)'(h_gap < 0))) >>> 1;
    assign left_c = left_x_reg + 8'(w_gap >> 1);
    assign top_c  = top_y_reg + h_half[7:0];

    assign row_ok   = !drow_reg[32] && (drow_reg[31:0] < 32'(crop_h_reg));
    assign col_ok   = col_reg < crop_w_reg;
    assign row_end  = (byte_in_row_reg + 34'd1) == row_bytes_reg;
    assign last_col = col_reg == (crop_w_reg - 1'b1);
    assign last_row = bottom_up_reg ? (drow_reg[31:0] == 32'd0)
                                    : (drow_reg[31:0] == 32'(crop_h_reg) - 32'd1);
    assign last     = last_col && last_row;

    always_comb begin
        byte_pos_next    = byte_pos_reg;
        phase_next       = phase_reg;
        shift_next       = shift_reg;
        data_start_next  = data_start_reg;
        image_width_next = image_width_reg;
        image_rows_next  = image_rows_reg;
        bottom_up_next   = bottom_up_reg;
        crop_w_next      = crop_w_reg;
        crop_h_next      = crop_h_reg;
        crop_empty_next  = crop_empty_reg;
        left_x_next      = left_x_reg;
        top_y_next       = top_y_reg;
        row_bytes_next   = row_bytes_reg;
        byte_in_row_next = byte_in_row_reg;
        col_next         = col_reg;
        comp_next        = comp_reg;
        drow_next        = drow_reg;
        held_bg_next     = held_bg_reg;
        bad              = 1'b0;
        res_valid        = 1'b0;
        res              = '0;

        if (step) begin
            byte_pos_next = (pos == '1) ? pos : pos + 32'd1;
            if (first_byte) begin
                phase_next = PH_HEADER;
                shift_next = '0;
            end
            unique case (phase_cur)
                PH_HEADER: begin
                    if (pos == 32'd0) begin
                        left_x_next    = origin_x;
                        top_y_next     = origin_y;
                        bottom_up_next = 1'b1;
                    end
                    if (pos == 32'd0 && off_screen) begin
                        phase_next = PH_DONE;
                    end else begin
                        shift_next = shift_new;
                        if (pos == POS_CROP) begin
                            crop_w_next     = w_c[CW-1:0];
                            crop_h_next     = h_c[CH-1:0];
                            crop_empty_next = (w_c <= 0) || (h_c <= 0);
                            row_bytes_next  = {rb_sum[33:2], 2'b00};
                        end
                        if (pos == POS_CENTRE) begin
                            left_x_next = left_c;
                            top_y_next  = top_c;
                        end
                        unique case (pos)
                            POS_SIG:    bad = shift_new[31:16] != BMP_SIGNATURE;
                            POS_OFFSET: data_start_next = shift_new;
                            POS_WIDTH:  image_width_next = shift_new;
                            POS_HEIGHT: begin
                                if (shift_new[31]) begin
                                    image_rows_next = 32'd0 - shift_new;
                                    bottom_up_next  = 1'b0;
                                end else begin
                                    image_rows_next = shift_new;
                                    bottom_up_next  = 1'b1;
                                end
                            end
                            POS_PLANES: bad = shift_new[31:16] != BMP_PLANES;
                            POS_DEPTH:  bad = shift_new[31:16] != BMP_DEPTH;
                            POS_COMP: begin
                                bad = (shift_new != 32'd0) || (data_start_reg < HEADER_LEN);
                                if (!bad) begin
                                    if (crop_empty_reg) begin
                                        phase_next = PH_DONE;
                                    end else begin
                                        phase_next       = PH_DATA;
                                        byte_in_row_next = '0;
                                        col_next         = '0;
                                        comp_next        = COMP_BLUE;
                                        drow_next        = bottom_up_reg
                                                         ? {1'b0, image_rows_reg} - 33'd1
                                                         : 33'd0;
                                    end
                                end
                            end
                            default: ;
                        endcase
                        if (bad) begin
                            phase_next      = PH_DONE;
                            res_valid       = 1'b1;
                            res.result_kind = KIND_REJECT;
                        end
                    end
                end
                PH_DATA: begin
                    if (pos >= data_start_reg) begin
                        if (row_ok && col_ok) begin
                            unique case (comp_reg)
                                COMP_BLUE:  held_bg_next = {8'd0, file_byte};
                                COMP_GREEN: held_bg_next = {file_byte, held_bg_reg[7:0]};
                                COMP_RED: begin
                                    res_valid       = 1'b1;
                                    res.result_kind = KIND_PIXEL;
                                    res.pixel_x     = 9'(col_reg) + 9'(left_x_reg);
                                    res.pixel_y     = drow_reg[9:0] + 10'(top_y_reg);
                                    res.red         = file_byte;
                                    res.green       = held_bg_reg[15:8];
                                    res.blue        = held_bg_reg[7:0];
                                    res.last_pixel  = last;
                                    if (last) begin
                                        phase_next = PH_DONE;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        if (row_end) begin
                            byte_in_row_next = '0;
                            col_next         = '0;
                            comp_next        = COMP_BLUE;
                            if (bottom_up_reg) begin
                                drow_next = drow_reg[32] ? drow_reg : drow_reg - 33'd1;
                            end else begin
                                drow_next = drow_reg + 33'd1;
                            end
                        end else begin
                            byte_in_row_next = byte_in_row_reg + 34'd1;
                            if (comp_reg == COMP_RED) begin
                                comp_next = COMP_BLUE;
                                col_next  = (col_reg == '1) ? col_reg : col_reg + 1'b1;
                            end else begin
                                comp_next = comp_reg + 2'd1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg    <= '0;
            phase_reg       <= PH_HEADER;
            shift_reg       <= '0;
            data_start_reg  <= '0;
            image_width_reg <= '0;
            image_rows_reg  <= '0;
            bottom_up_reg   <= 1'b1;
            crop_w_reg      <= '0;
            crop_h_reg      <= '0;
            crop_empty_reg  <= 1'b1;
            left_x_reg      <= '0;
            top_y_reg       <= '0;
            row_bytes_reg   <= '0;
            byte_in_row_reg <= '0;
            col_reg         <= '0;
            comp_reg        <= COMP_BLUE;
            drow_reg        <= '0;
            held_bg_reg     <= '0;
        end else begin
            byte_pos_reg    <= byte_pos_next;
            phase_reg       <= phase_next;
            shift_reg       <= shift_next;
            data_start_reg  <= data_start_next;
            image_width_reg <= image_width_next;
            image_rows_reg  <= image_rows_next;
            bottom_up_reg   <= bottom_up_next;
            crop_w_reg      <= crop_w_next;
            crop_h_reg      <= crop_h_next;
            crop_empty_reg  <= crop_empty_next;
            left_x_reg      <= left_x_next;
            top_y_reg       <= top_y_next;
            row_bytes_reg   <= row_bytes_next;
            byte_in_row_reg <= byte_in_row_next;
            col_reg         <= col_next;
            comp_reg        <= comp_next;
            drow_reg        <= drow_next;
            held_bg_reg     <= held_bg_next;
        end
    end

endmodule

@@ src/bmp24_stream_to_pixels.sv @@
// ============================================================================
// bmp24_stream_to_pixels
// Decodes a 24-bit uncompressed BMP byte stream into positioned pixels.
// ============================================================================
// The s_ channel carries the file one byte per transaction; s_first_byte marks
// the first byte of a new file and restarts header parsing. The m_ channel
// carries one transaction per pixel to draw, or a single rejection when the
// header is not a plain 24-bit, one-plane, uncompressed bitmap.
// The origin registers are written through cfg_wr_en, cfg_index and cfg_wdata
// and are sampled at the first byte of each file.
// A byte is taken every cycle while the skid register is empty. The pixel of a
// transaction that carries its red byte is registered in the output register,
// or in the skid register when the receiver stalls. Throughput is one byte per
// cycle while s_ready is high, set by the single parser pass before the register.
// When the receiver stalls, one further result is held in a skid register;
// s_ready falls only once that register is occupied and rises again as soon
// as the receiver takes a result.
// Synchronous reset clears the origins to zero, empties the output stages and
// returns the parser to the start of a header.
// ============================================================================
module bmp24_stream_to_pixels
    import bmp24_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_file_byte,
    input  logic       s_first_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_result_kind,
    output logic [8:0] m_pixel_x,
    output logic [9:0] m_pixel_y,
    output logic [7:0] m_red,
    output logic [7:0] m_green,
    output logic [7:0] m_blue,
    output logic       m_last_pixel
);

    logic [7:0] origin_x_reg, origin_y_reg;
    logic       out_valid_reg, skid_valid_reg;
    result_t    out_reg, skid_reg;
    logic       step, res_valid, out_free;
    result_t    res;

    assign s_ready  = !skid_valid_reg;
    assign step     = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ORIGIN_X: origin_x_reg <= cfg_wdata;
                CFG_ORIGIN_Y: origin_y_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    bmp24_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .file_byte  (s_file_byte),
        .first_byte (s_first_byte),
        .origin_x   (origin_x_reg),
        .origin_y   (origin_y_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_free) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (out_free) begin
            out_valid_reg <= step && res_valid;
        end else if (step && res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_free) begin
                out_reg <= skid_reg;
            end
        end else if (out_free) begin
            out_reg <= res;
        end else begin
            skid_reg <= res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_result_kind = out_reg.result_kind;
    assign m_pixel_x     = out_reg.pixel_x;
    assign m_pixel_y     = out_reg.pixel_y;
    assign m_red         = out_reg.red;
    assign m_green       = out_reg.green;
    assign m_blue        = out_reg.blue;
    assign m_last_pixel  = out_reg.last_pixel;

endmodule

@@ src/bmp24_checker.sv @@
// ============================================================================
// bmp24_checker
// Port-level checks on the result channel of the BMP stream decoder.
// ============================================================================
module bmp24_checker
    import bmp24_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_result_kind,
    input logic [8:0] m_pixel_x,
    input logic [9:0] m_pixel_y,
    input logic [7:0] m_red,
    input logic [7:0] m_green,
    input logic [7:0] m_blue,
    input logic       m_last_pixel
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_kind) && $stable(m_pixel_x)
            && $stable(m_pixel_y) && $stable(m_red) && $stable(m_green)
            && $stable(m_blue) && $stable(m_last_pixel))
        else $error("result transaction changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result channel not empty after reset");

    a_reject_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == KIND_REJECT |-> m_pixel_x == '0 && m_pixel_y == '0
            && m_red == '0 && m_green == '0 && m_blue == '0 && !m_last_pixel)
        else $error("rejection carries pixel data");

    a_last_is_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_pixel |-> m_result_kind == KIND_PIXEL)
        else $error("frame end flagged on a rejection");

endmodule

bind bmp24_stream_to_pixels bmp24_checker u_checker (.*);
